### hdl/rk4s_pkg.sv
// rk4s_pkg: shared constants, types and saturation helper for the RK4 grid step block.
// Depends on nothing; used by every module under hdl except rk4s_ram.
`default_nettype none
package rk4s_pkg;

    localparam int MAX_POINTS = 4096;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int DATA_W     = 32;
    localparam int SUM_W      = 36;
    localparam int A_W        = 3 * DATA_W;                 // {wave_re, wave_im, pot}
    localparam int B_W        = 2 * DATA_W + 2 * SUM_W;     // {stage_re, stage_im, sum_re, sum_im}
    localparam int DRAIN_CYCLES = 8;
    localparam int DRAIN_W    = $clog2(DRAIN_CYCLES);

    localparam logic [24:0] LAP_RESET  = 25'd4194304;
    localparam logic [12:0] NPTS_RESET = 13'd4096;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_STEP = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic REG_LAP  = 1'b0;
    localparam logic REG_NPTS = 1'b1;

    // floor(2^35 / 3), split for two 34x17 partial products
    localparam logic [33:0] DIV3_M  = 34'd11453246122;
    localparam logic [16:0] DIV3_ML = DIV3_M[16:0];
    localparam logic [16:0] DIV3_MH = DIV3_M[33:17];

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic              interior;
        logic              jge2;
        logic [1:0]        stage;
    } ctl_t;

    typedef struct packed {
        logic               ovf;
        logic signed [31:0] val;
    } sat_t;

    function automatic sat_t sat32(input logic signed [47:0] x);
        sat_t r;
        if (x > 48'sd2147483647) begin
            r.ovf = 1'b1;
            r.val = 32'sh7FFFFFFF;
        end else if (x < -48'sd2147483648) begin
            r.ovf = 1'b1;
            r.val = 32'sh80000000;
        end else begin
            r.ovf = 1'b0;
            r.val = x[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/rk4s_ram.sv
// rk4s_ram: generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none
module rk4s_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### hdl/rk4s_stage_unit.sv
// rk4s_stage_unit: one RK4 stage per sweep; builds p, a 3-point window, the Laplacian,
// the products and k, and writes stage and running sum back. Uses rk4s_pkg.
`default_nettype none
module rk4s_stage_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rk4s_pkg::ctl_t                ctl,
    input  logic [24:0]                   lap_coef,
    input  logic [rk4s_pkg::A_W-1:0]      a_rdata,
    input  logic [rk4s_pkg::B_W-1:0]      b_rdata,
    output logic                          b_we,
    output logic [rk4s_pkg::ADDR_W-1:0]   b_waddr,
    output logic [rk4s_pkg::B_W-1:0]      b_wdata,
    output logic                          sat_pulse
);

    // S1: stage input p = phi + f*k_prev
    logic signed [31:0] wv_re, wv_im, pot, st_re, st_im, kp_re, kp_im;
    logic signed [35:0] sum_in_re, sum_in_im;
    rk4s_pkg::sat_t p_re, p_im;

    assign wv_re     = a_rdata[95:64];
    assign wv_im     = a_rdata[63:32];
    assign pot       = a_rdata[31:0];
    assign st_re     = b_rdata[135:104];
    assign st_im     = b_rdata[103:72];
    assign sum_in_re = b_rdata[71:36];
    assign sum_in_im = b_rdata[35:0];

    always_comb
    begin
        kp_re = '0;
        kp_im = '0;
        if (ctl.interior && ctl.stage != 2'd0)
        begin
            kp_re = (ctl.stage == 2'd3) ? st_re : (st_re >>> 1);
            kp_im = (ctl.stage == 2'd3) ? st_im : (st_im >>> 1);
        end
        p_re = rk4s_pkg::sat32(48'(wv_re) + 48'(kp_re));
        p_im = rk4s_pkg::sat32(48'(wv_im) + 48'(kp_im));
    end

    // S2: window, index 2 newest, 1 is the center point
    logic signed [31:0] pw_re_reg [3];
    logic signed [31:0] pw_im_reg [3];
    logic signed [31:0] ww_reg [2];
    logic signed [35:0] sw_re_reg [2];
    logic signed [35:0] sw_im_reg [2];
    logic [rk4s_pkg::ADDR_W-1:0] aw_reg [2];
    logic [1:0] stg2_reg;
    logic v2_reg, psat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg   <= 1'b0;
            psat_reg <= 1'b0;
        end else begin
            v2_reg   <= ctl.valid && ctl.jge2;
            psat_reg <= ctl.valid && (p_re.ovf || p_im.ovf);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            pw_re_reg[0] <= pw_re_reg[1];
            pw_re_reg[1] <= pw_re_reg[2];
            pw_re_reg[2] <= p_re.val;
            pw_im_reg[0] <= pw_im_reg[1];
            pw_im_reg[1] <= pw_im_reg[2];
            pw_im_reg[2] <= p_im.val;
            ww_reg[0]    <= ww_reg[1];
            ww_reg[1]    <= pot;
            sw_re_reg[0] <= sw_re_reg[1];
            sw_re_reg[1] <= sum_in_re;
            sw_im_reg[0] <= sw_im_reg[1];
            sw_im_reg[1] <= sum_in_im;
            aw_reg[0]    <= aw_reg[1];
            aw_reg[1]    <= ctl.addr;
            stg2_reg     <= ctl.stage;
        end
    end

    // S3: Laplacian of the center point
    logic signed [33:0] lap_re_reg, lap_im_reg;
    logic signed [31:0] pc_re_reg, pc_im_reg, wc_reg;
    logic signed [35:0] sc_re_reg, sc_im_reg, sd_re_reg, sd_im_reg;
    logic [rk4s_pkg::ADDR_W-1:0] ac_reg, ad_reg;
    logic [1:0] stg3_reg, stg4_reg;
    logic v3_reg, v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lap_re_reg <= 34'(pw_re_reg[2]) - (34'(pw_re_reg[1]) <<< 1) + 34'(pw_re_reg[0]);
        lap_im_reg <= 34'(pw_im_reg[2]) - (34'(pw_im_reg[1]) <<< 1) + 34'(pw_im_reg[0]);
        pc_re_reg  <= pw_re_reg[1];
        pc_im_reg  <= pw_im_reg[1];
        wc_reg     <= ww_reg[0];
        sc_re_reg  <= sw_re_reg[0];
        sc_im_reg  <= sw_im_reg[0];
        ac_reg     <= aw_reg[0];
        stg3_reg   <= stg2_reg;
    end

    // S4: products
    logic signed [59:0] clp_re_reg, clp_im_reg;
    logic signed [63:0] wpp_re_reg, wpp_im_reg;
    logic signed [25:0] c_s;

    assign c_s = $signed({1'b0, lap_coef});

    always_ff @(posedge clk)
    begin
        clp_re_reg <= c_s * lap_re_reg;
        clp_im_reg <= c_s * lap_im_reg;
        wpp_re_reg <= wc_reg * pc_re_reg;
        wpp_im_reg <= wc_reg * pc_im_reg;
        sd_re_reg  <= sc_re_reg;
        sd_im_reg  <= sc_im_reg;
        ad_reg     <= ac_reg;
        stg4_reg   <= stg3_reg;
    end

    // S5: round, k, sum accumulate, write back
    logic signed [59:0] clr_re, clr_im;
    logic signed [63:0] wpr_re, wpr_im;
    logic signed [35:0] cl_re, cl_im, kx_re, kx_im, sum_next_re, sum_next_im;
    logic signed [39:0] wp_re, wp_im;
    rk4s_pkg::sat_t k_re, k_im;

    always_comb
    begin
        clr_re = (clp_re_reg + 60'sd8388608) >>> 24;
        clr_im = (clp_im_reg + 60'sd8388608) >>> 24;
        wpr_re = (wpp_re_reg + 64'sd8388608) >>> 24;
        wpr_im = (wpp_im_reg + 64'sd8388608) >>> 24;
        cl_re  = clr_re[35:0];
        cl_im  = clr_im[35:0];
        wp_re  = wpr_re[39:0];
        wp_im  = wpr_im[39:0];
        k_re   = rk4s_pkg::sat32(48'(wp_im) - 48'(cl_im));
        k_im   = rk4s_pkg::sat32(48'(cl_re) - 48'(wp_re));
        kx_re  = 36'(k_re.val);
        kx_im  = 36'(k_im.val);
        case (stg4_reg)
            2'd0:
            begin
                sum_next_re = kx_re;
                sum_next_im = kx_im;
            end
            2'd3:
            begin
                sum_next_re = sd_re_reg + kx_re;
                sum_next_im = sd_im_reg + kx_im;
            end
            default:
            begin
                sum_next_re = sd_re_reg + (kx_re <<< 1);
                sum_next_im = sd_im_reg + (kx_im <<< 1);
            end
        endcase
    end

    assign b_we      = v4_reg;
    assign b_waddr   = ad_reg;
    assign b_wdata   = {k_re.val, k_im.val, sum_next_re, sum_next_im};
    assign sat_pulse = psat_reg || (v4_reg && (k_re.ovf || k_im.ovf));

endmodule
`default_nettype wire

### hdl/rk4s_update_unit.sv
// rk4s_update_unit: final sweep, phi += sum/6 rounded half away from zero, saturated.
// Divide by 6 as halve then reciprocal multiply by 1/3 with one correction. Uses rk4s_pkg.
`default_nettype none
module rk4s_update_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rk4s_pkg::ctl_t                ctl,
    input  logic [rk4s_pkg::A_W-1:0]      a_rdata,
    input  logic [rk4s_pkg::B_W-1:0]      b_rdata,
    output logic                          a_we,
    output logic [rk4s_pkg::ADDR_W-1:0]   a_waddr,
    output logic [rk4s_pkg::A_W-1:0]      a_wdata,
    output logic                          sat_pulse
);

    logic signed [35:0] x_re, x_im;
    logic [35:0] mag_re, mag_im, ap_re, ap_im;
    logic [33:0] h_re, h_im;

    assign x_re = b_rdata[71:36];
    assign x_im = b_rdata[35:0];

    always_comb
    begin
        mag_re = x_re[35] ? 36'(-x_re) : 36'(x_re);
        mag_im = x_im[35] ? 36'(-x_im) : 36'(x_im);
        ap_re  = mag_re + 36'd3;
        ap_im  = mag_im + 36'd3;
        h_re   = ap_re[34:1];
        h_im   = ap_im[34:1];
    end

    // U1: partial products
    logic [50:0] pl_re_reg, ph_re_reg, pl_im_reg, ph_im_reg;
    logic [33:0] h1_re_reg, h1_im_reg, h2_re_reg, h2_im_reg, h3_re_reg, h3_im_reg;
    logic n1_re_reg, n1_im_reg, n2_re_reg, n2_im_reg, n3_re_reg, n3_im_reg;
    logic [rk4s_pkg::A_W-1:0] w1_reg, w2_reg, w3_reg;
    logic [rk4s_pkg::ADDR_W-1:0] a1_reg, a2_reg, a3_reg;
    logic v1_reg, v2_reg, v3_reg;
    logic [32:0] q0_re_reg, q0_im_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= ctl.valid && ctl.interior;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    logic [67:0] prod_re, prod_im;

    always_comb
    begin
        prod_re = (68'(ph_re_reg) << 17) + 68'(pl_re_reg);
        prod_im = (68'(ph_im_reg) << 17) + 68'(pl_im_reg);
    end

    always_ff @(posedge clk)
    begin
        pl_re_reg <= h_re * rk4s_pkg::DIV3_ML;
        ph_re_reg <= h_re * rk4s_pkg::DIV3_MH;
        pl_im_reg <= h_im * rk4s_pkg::DIV3_ML;
        ph_im_reg <= h_im * rk4s_pkg::DIV3_MH;
        h1_re_reg <= h_re;
        h1_im_reg <= h_im;
        n1_re_reg <= x_re[35];
        n1_im_reg <= x_im[35];
        w1_reg    <= a_rdata;
        a1_reg    <= ctl.addr;
        // U2: quotient estimate, at most one low
        q0_re_reg <= prod_re[67:35];
        q0_im_reg <= prod_im[67:35];
        h2_re_reg <= h1_re_reg;
        h2_im_reg <= h1_im_reg;
        n2_re_reg <= n1_re_reg;
        n2_im_reg <= n1_im_reg;
        w2_reg    <= w1_reg;
        a2_reg    <= a1_reg;
        h3_re_reg <= h2_re_reg;
        h3_im_reg <= h2_im_reg;
        n3_re_reg <= n2_re_reg;
        n3_im_reg <= n2_im_reg;
        w3_reg    <= w2_reg;
        a3_reg    <= a2_reg;
    end

    // U3: correction, sign, add, saturate
    logic [32:0] q1_re_reg, q1_im_reg;
    logic [35:0] r_re, r_im;
    logic [33:0] q_re, q_im;
    logic signed [47:0] d_re, d_im;
    logic signed [31:0] ph_re, ph_im;
    rk4s_pkg::sat_t nw_re, nw_im;

    always_ff @(posedge clk)
    begin
        q1_re_reg <= q0_re_reg;
        q1_im_reg <= q0_im_reg;
    end

    always_comb
    begin
        r_re  = 36'(h3_re_reg) - (36'(q1_re_reg) + (36'(q1_re_reg) << 1));
        r_im  = 36'(h3_im_reg) - (36'(q1_im_reg) + (36'(q1_im_reg) << 1));
        q_re  = (r_re >= 36'd3) ? 34'(q1_re_reg) + 34'd1 : 34'(q1_re_reg);
        q_im  = (r_im >= 36'd3) ? 34'(q1_im_reg) + 34'd1 : 34'(q1_im_reg);
        d_re  = n3_re_reg ? -$signed(48'(q_re)) : $signed(48'(q_re));
        d_im  = n3_im_reg ? -$signed(48'(q_im)) : $signed(48'(q_im));
        ph_re = w3_reg[95:64];
        ph_im = w3_reg[63:32];
        nw_re = rk4s_pkg::sat32(48'(ph_re) + d_re);
        nw_im = rk4s_pkg::sat32(48'(ph_im) + d_im);
    end

    assign a_we      = v3_reg;
    assign a_waddr   = a3_reg;
    assign a_wdata   = {nw_re.val, nw_im.val, w3_reg[31:0]};
    assign sat_pulse = v3_reg && (nw_re.ovf || nw_im.ovf);

endmodule
`default_nettype wire

### hdl/rk4_schrodinger_grid_step.sv
// rk4_schrodinger_grid_step: top level, sequencer, APB registers, and the two state RAMs.
// Depends on rk4s_pkg, rk4s_ram, rk4s_stage_unit and rk4s_update_unit.
//
// One complex wave function and dt*V per grid point live in RAM A ({re, im, pot}); RK4
// stage values and running sums live in RAM B. A load (op 0) goes from idle straight to the
// finish state; a read (op 2) first passes the read state, which takes the RAM data. A step
// (op 1) makes five sweeps over the n active points, one point per cycle through the RAM
// read port: four stage sweeps then one update sweep, each followed by a drain. With n below
// 3 a step makes no sweep. The sweep length, set by the single read port per RAM, fixes the
// rate.
// Each sweep writes an entry only after reading it, and the drain lets the last writes land
// before the next sweep reads. No clearing pass is needed after reset. A new input transfer
// is taken whenever the sequencer is idle, even while the previous result waits in the
// output register. saturated is set when any clip happened during that step.
`default_nettype none
module rk4_schrodinger_grid_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [11:0]        index,
    input  logic signed [31:0] load_re,
    input  logic signed [31:0] load_im,
    input  logic signed [31:0] load_pot,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [11:0]        out_index,
    output logic signed [31:0] out_re,
    output logic signed [31:0] out_im,
    output logic               saturated
);

    localparam int AW = rk4s_pkg::ADDR_W;
    localparam int CW = rk4s_pkg::CNT_W;

    // Configuration registers
    logic [24:0] lap_coef_reg;
    logic [12:0] n_points_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lap_coef_reg <= rk4s_pkg::LAP_RESET;
            n_points_reg <= rk4s_pkg::NPTS_RESET;
        end else if (cfg_wr)
        begin
            unique case (paddr[2])
                rk4s_pkg::REG_LAP:  lap_coef_reg <= pwdata[24:0];
                rk4s_pkg::REG_NPTS: n_points_reg <= pwdata[12:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            rk4s_pkg::REG_LAP:  prdata = 32'(lap_coef_reg);
            rk4s_pkg::REG_NPTS: prdata = 32'(n_points_reg);
        endcase
    end

    // Active point count, clamped to the RAM depth
    logic [CW-1:0] n_eff;

    always_comb
    begin
        if (32'(n_points_reg) > rk4s_pkg::MAX_POINTS)
            n_eff = CW'(rk4s_pkg::MAX_POINTS);
        else
            n_eff = CW'(n_points_reg);
    end

    // Sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_PASS,
        ST_UPD,
        ST_DRAIN,
        ST_FIN
    } state_t;

    state_t                    state_reg;
    logic [CW-1:0]             j_reg;
    logic [1:0]                s_reg;
    logic                      upd_reg;
    logic [rk4s_pkg::DRAIN_W-1:0] drain_reg;
    logic [1:0]                op_reg;
    logic [11:0]               idx_reg;
    logic                      in_range_reg;
    logic signed [31:0]        res_re_reg, res_im_reg;
    logic                      sat_reg;
    logic                      out_valid_reg;
    logic [11:0]               out_index_reg;
    logic signed [31:0]        out_re_reg, out_im_reg;
    logic                      out_sat_reg;
    rk4s_pkg::ctl_t            ctl_reg;

    logic accept, in_range;
    logic stg_sat, upd_sat;
    logic [rk4s_pkg::A_W-1:0] a_rdata;
    logic [rk4s_pkg::B_W-1:0] b_rdata;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign in_range = 32'(index) < rk4s_pkg::MAX_POINTS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            j_reg         <= '0;
            s_reg         <= '0;
            upd_reg       <= 1'b0;
            drain_reg     <= '0;
            op_reg        <= rk4s_pkg::OP_LOAD;
            idx_reg       <= '0;
            in_range_reg  <= 1'b0;
            res_re_reg    <= '0;
            res_im_reg    <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            out_re_reg    <= '0;
            out_im_reg    <= '0;
            out_sat_reg   <= 1'b0;
            ctl_reg       <= '0;
        end else begin
            // read issue info is registered so it lines up with the registered RAM data
            ctl_reg.valid    <= (state_reg == ST_PASS) || (state_reg == ST_UPD);
            ctl_reg.addr     <= j_reg[AW-1:0];
            ctl_reg.interior <= (j_reg != '0) && (j_reg != n_eff - CW'(1));
            ctl_reg.jge2     <= j_reg >= CW'(2);
            ctl_reg.stage    <= s_reg;

            // in ST_FIN the output register is reloaded below
            if (out_valid_reg && out_ready && state_reg != ST_FIN)
                out_valid_reg <= 1'b0;

            if (state_reg != ST_IDLE)
                sat_reg <= sat_reg || stg_sat || upd_sat;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg     <= op;
                        idx_reg    <= index;
                        res_re_reg <= '0;
                        res_im_reg <= '0;
                        sat_reg    <= 1'b0;
                        j_reg      <= '0;
                        s_reg      <= '0;
                        upd_reg    <= 1'b0;
                        unique case (op)
                            rk4s_pkg::OP_READ:
                            begin
                                in_range_reg <= in_range;
                                state_reg    <= ST_READ;
                            end
                            rk4s_pkg::OP_STEP:
                            begin
                                if (n_eff < CW'(3))
                                    state_reg <= ST_FIN;
                                else
                                    state_reg <= ST_PASS;
                            end
                            default: state_reg <= ST_FIN;
                        endcase
                    end
                end
                ST_READ:
                begin
                    if (in_range_reg)
                    begin
                        res_re_reg <= a_rdata[95:64];
                        res_im_reg <= a_rdata[63:32];
                    end
                    state_reg <= ST_FIN;
                end
                ST_PASS, ST_UPD:
                begin
                    if (j_reg == n_eff - CW'(1))
                    begin
                        j_reg     <= '0;
                        drain_reg <= '0;
                        state_reg <= ST_DRAIN;
                    end else begin
                        j_reg <= j_reg + CW'(1);
                    end
                end
                ST_DRAIN:
                begin
                    drain_reg <= drain_reg + rk4s_pkg::DRAIN_W'(1);
                    if (drain_reg == rk4s_pkg::DRAIN_W'(rk4s_pkg::DRAIN_CYCLES - 1))
                    begin
                        if (upd_reg)
                            state_reg <= ST_FIN;
                        else if (s_reg == 2'd3)
                        begin
                            upd_reg   <= 1'b1;
                            state_reg <= ST_UPD;
                        end else begin
                            s_reg     <= s_reg + 2'd1;
                            state_reg <= ST_PASS;
                        end
                    end
                end
                ST_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_index_reg <= (op_reg == rk4s_pkg::OP_LOAD ||
                                          op_reg == rk4s_pkg::OP_READ) ? idx_reg : '0;
                        out_re_reg    <= res_re_reg;
                        out_im_reg    <= res_im_reg;
                        out_sat_reg   <= (op_reg == rk4s_pkg::OP_STEP) && sat_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_re    = out_re_reg;
    assign out_im    = out_im_reg;
    assign saturated = out_sat_reg;

    // Datapath units
    rk4s_pkg::ctl_t stg_ctl, upd_ctl;

    always_comb
    begin
        stg_ctl       = ctl_reg;
        stg_ctl.valid = ctl_reg.valid && !upd_reg;
        upd_ctl       = ctl_reg;
        upd_ctl.valid = ctl_reg.valid && upd_reg;
    end

    logic                     b_we, upd_we, a_we;
    logic [AW-1:0]            b_waddr, upd_waddr, a_waddr, a_raddr;
    logic [rk4s_pkg::B_W-1:0] b_wdata;
    logic [rk4s_pkg::A_W-1:0] upd_wdata, a_wdata;

    rk4s_stage_unit u_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (stg_ctl),
        .lap_coef  (lap_coef_reg),
        .a_rdata   (a_rdata),
        .b_rdata   (b_rdata),
        .b_we      (b_we),
        .b_waddr   (b_waddr),
        .b_wdata   (b_wdata),
        .sat_pulse (stg_sat)
    );

    rk4s_update_unit u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (upd_ctl),
        .a_rdata   (a_rdata),
        .b_rdata   (b_rdata),
        .a_we      (upd_we),
        .a_waddr   (upd_waddr),
        .a_wdata   (upd_wdata),
        .sat_pulse (upd_sat)
    );

    // RAM A port muxing: load transfers in idle, update sweep otherwise
    assign a_we    = (accept && op == rk4s_pkg::OP_LOAD && in_range) || upd_we;
    assign a_waddr = upd_we ? upd_waddr : AW'(index);
    assign a_wdata = upd_we ? upd_wdata : {load_re, load_im, load_pot};
    assign a_raddr = (state_reg == ST_IDLE) ? AW'(index) : j_reg[AW-1:0];

    rk4s_ram #(
        .WIDTH (rk4s_pkg::A_W),
        .DEPTH (rk4s_pkg::MAX_POINTS)
    ) u_ram_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    rk4s_ram #(
        .WIDTH (rk4s_pkg::B_W),
        .DEPTH (rk4s_pkg::MAX_POINTS)
    ) u_ram_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (j_reg[AW-1:0]),
        .rdata (b_rdata)
    );

`ifndef SYNTH
    // stage RAM is written only during stage sweeps and their drain
    a_b_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        b_we |-> (state_reg == ST_PASS || state_reg == ST_DRAIN))
        else $error("stage RAM written outside a stage sweep");

    // in idle, a wave RAM write comes only from a load transfer
    a_idle_write_is_load: assert property (@(posedge clk) disable iff (!rst_n)
        (a_we && state_reg == ST_IDLE) |-> (accept && op == rk4s_pkg::OP_LOAD))
        else $error("wave RAM written in idle without a load");

    // update and stage units never both active
    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(b_we && upd_we))
        else $error("stage and update writes overlap");

    // saturated is only reported on a step result, which carries index zero
    a_sat_step_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> (out_index == 12'd0))
        else $error("saturated flag on a non-step result");
`endif

endmodule
`default_nettype wire

### tb/rk4_grid_step_checker.sv
// rk4_grid_step_checker: watches the APB, input and output channels of the RK4 grid step block,
// keeps its own copy of the grid and registers, predicts each result and compares it.
// Depends on rk4s_pkg for the op codes.
`default_nettype none
module rk4_grid_step_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         op,
    input  logic [11:0]        index,
    input  logic signed [31:0] load_re,
    input  logic signed [31:0] load_im,
    input  logic signed [31:0] load_pot,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [11:0]        out_index,
    input  logic signed [31:0] out_re,
    input  logic signed [31:0] out_im,
    input  logic               saturated,
    output int                 errors,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint HALF_LSB = 64'sd8388608;

    typedef struct {
        logic [11:0]        idx;
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               sat;
    } grid_result_t;

    grid_result_t results_due[$];

    logic [24:0] lap_coef;
    logic [12:0] n_points;

    int     wave_re  [rk4s_pkg::MAX_POINTS];
    int     wave_im  [rk4s_pkg::MAX_POINTS];
    int     pot_dt   [rk4s_pkg::MAX_POINTS];
    int     stage_re [rk4s_pkg::MAX_POINTS];
    int     stage_im [rk4s_pkg::MAX_POINTS];
    longint sum_re   [rk4s_pkg::MAX_POINTS];
    longint sum_im   [rk4s_pkg::MAX_POINTS];
    int     p_re     [rk4s_pkg::MAX_POINTS];
    int     p_im     [rk4s_pkg::MAX_POINTS];
    bit     clipped;

    function automatic int clip32(longint x);
        if (x > S32_MAX)
        begin
            clipped = 1'b1;
            return int'(S32_MAX);
        end
        if (x < S32_MIN)
        begin
            clipped = 1'b1;
            return int'(S32_MIN);
        end
        return int'(x);
    endfunction

    function automatic longint round24(longint x);
        return (x + HALF_LSB) >>> 24;
    endfunction

    // divide by six, round to nearest, ties away from zero
    function automatic longint div6_nearest(longint x);
        if (x >= 0)
            return (x + 3) / 6;
        return -((-x + 3) / 6);
    endfunction

    // one RK4 time step over n points, end points held
    function automatic void rk4_advance(int n);
        longint c;
        longint kr;
        longint ki;
        longint lr;
        longint li;
        longint w;
        int     r;
        int     m;
        c = longint'(lap_coef);
        for (int s = 0; s < 4; s++)
        begin
            for (int j = 0; j < n; j++)
            begin
                kr = 0;
                ki = 0;
                if (s > 0 && j != 0 && j != n - 1)
                begin
                    kr = stage_re[j];
                    ki = stage_im[j];
                    if (s < 3)
                    begin
                        kr = kr >>> 1;
                        ki = ki >>> 1;
                    end
                end
                p_re[j] = clip32(longint'(wave_re[j]) + kr);
                p_im[j] = clip32(longint'(wave_im[j]) + ki);
            end
            for (int j = 1; j + 1 < n; j++)
            begin
                lr = longint'(p_re[j+1]) - 2 * longint'(p_re[j]) + longint'(p_re[j-1]);
                li = longint'(p_im[j+1]) - 2 * longint'(p_im[j]) + longint'(p_im[j-1]);
                w  = pot_dt[j];
                r  = clip32(round24(w * p_im[j]) - round24(c * li));
                m  = clip32(round24(c * lr) - round24(w * p_re[j]));
                stage_re[j] = r;
                stage_im[j] = m;
                if (s == 0)
                begin
                    sum_re[j] = r;
                    sum_im[j] = m;
                end
                else if (s < 3)
                begin
                    sum_re[j] += 2 * longint'(r);
                    sum_im[j] += 2 * longint'(m);
                end
                else
                begin
                    sum_re[j] += r;
                    sum_im[j] += m;
                end
            end
        end
        for (int j = 1; j + 1 < n; j++)
        begin
            wave_re[j] = clip32(longint'(wave_re[j]) + div6_nearest(sum_re[j]));
            wave_im[j] = clip32(longint'(wave_im[j]) + div6_nearest(sum_im[j]));
        end
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grid_result_t r;
        grid_result_t e;
        int n;
        if (!rst_n)
        begin
            lap_coef = rk4s_pkg::LAP_RESET;
            n_points = rk4s_pkg::NPTS_RESET;
            errors   = 0;
            pending  <= 0;
            results_due.delete();
            for (int j = 0; j < rk4s_pkg::MAX_POINTS; j++)
            begin
                stage_re[j] = 0;
                stage_im[j] = 0;
                sum_re[j]   = 0;
                sum_im[j]   = 0;
            end
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == 3'd4 * rk4s_pkg::REG_LAP)
                    lap_coef = pwdata[24:0];
                else if (paddr == 3'd4 * rk4s_pkg::REG_NPTS)
                    n_points = pwdata[12:0];
            end

            if (in_valid && in_ready)
            begin
                r.idx = 12'd0;
                r.re  = 32'sd0;
                r.im  = 32'sd0;
                r.sat = 1'b0;
                case (op)
                    rk4s_pkg::OP_LOAD:
                    begin
                        r.idx = index;
                        wave_re[index] = load_re;
                        wave_im[index] = load_im;
                        pot_dt[index]  = load_pot;
                    end
                    rk4s_pkg::OP_READ:
                    begin
                        r.idx = index;
                        r.re  = wave_re[index];
                        r.im  = wave_im[index];
                    end
                    rk4s_pkg::OP_STEP:
                    begin
                        n = (n_points > rk4s_pkg::MAX_POINTS) ? rk4s_pkg::MAX_POINTS
                                                              : int'(n_points);
                        clipped = 1'b0;
                        if (n >= 3)
                            rk4_advance(n);
                        r.sat = clipped;
                    end
                    default: ;
                endcase
                results_due.push_back(r);
            end

            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected", $realtime);
                    errors++;
                end
                else
                begin
                    e = results_due.pop_front();
                    if (out_index !== e.idx)
                        report("out_index", longint'(out_index), longint'(e.idx));
                    if (out_re !== e.re)
                        report("out_re", longint'(out_re), longint'(e.re));
                    if (out_im !== e.im)
                        report("out_im", longint'(out_im), longint'(e.im));
                    if (saturated !== e.sat)
                        report("saturated", longint'(saturated), longint'(e.sat));
                end
            end
            pending <= results_due.size();
        end
    end
endmodule
`default_nettype wire

### tb/rk4_schrodinger_grid_step_tb.sv
// rk4_schrodinger_grid_step_tb: stimulus, reset, clock and verdict for the RK4 grid step block.
// Depends on rk4s_pkg, the block under hdl, and rk4_grid_step_checker.
`default_nettype none
module rk4_schrodinger_grid_step_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         op = rk4s_pkg::OP_LOAD;
    logic [11:0]        index = '0;
    logic signed [31:0] load_re = '0;
    logic signed [31:0] load_im = '0;
    logic signed [31:0] load_pot = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [11:0]        out_index;
    logic signed [31:0] out_re;
    logic signed [31:0] out_im;
    logic               saturated;

    int errors;
    int pending;

    // run bookkeeping
    int  cycles = 0;
    int  accepted = 0;
    int  n_loads = 0;
    int  n_reads = 0;
    int  n_steps = 0;
    bit  calm = 1'b0;          // last part: no idling on either side
    bit  bursty = 1'b1;        // sender idles in bursts while set
    bit  long_hold_done = 1'b0;
    bit  written [rk4s_pkg::MAX_POINTS];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    rk4_schrodinger_grid_step u_top (.*);

    rk4_grid_step_checker u_chk (.*);

    // timeout guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("rk4_schrodinger_grid_step: mismatch");
            $finish;
        end
    end

    // Result side: one long hold-off early on so the block backs up and
    // stalls its input, then random stall bursts until the calm tail.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && !long_hold_done && accepted >= 30)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                long_hold_done = 1'b1;
                out_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // register write: setup then access phase
    task automatic reg_write(logic reg_sel, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'd4 * reg_sel;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drain all outstanding results before touching the registers
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // one input transfer; valid holds until accepted, then maybe an idle burst
    task automatic send(logic [1:0] o, logic [11:0] i,
                        logic [31:0] re, logic [31:0] im, logic [31:0] pot);
        in_valid <= 1'b1;
        op       <= o;
        index    <= i;
        load_re  <= re;
        load_im  <= im;
        load_pot <= pot;
        do
            @(posedge clk);
        while (!in_ready);
        accepted++;
        case (o)
            rk4s_pkg::OP_LOAD:
            begin
                n_loads++;
                written[i] = 1'b1;
            end
            rk4s_pkg::OP_READ: n_reads++;
            default: n_steps++;
        endcase
        if (accepted % 16 == 0)
            bursty = $urandom_range(0, 1);
        if (!calm && bursty && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // mostly moderate Q8.24 values so steps stay in range, sometimes full scale
    function automatic logic [31:0] wave_value();
        if ($urandom_range(0, 9) < 7)
            return 32'($signed($urandom_range(0, 32'h03FF_FFFF)) - 32'sh0200_0000);
        return $urandom;
    endfunction

    task automatic load_grid(int n);
        for (int j = 0; j < n; j++)
            send(rk4s_pkg::OP_LOAD, 12'(j), wave_value(), wave_value(), wave_value());
    endtask

    initial
    begin
        int n;
        int pick;
        logic [11:0] ix;
        logic [24:0] lap;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full-scale lap coefficient on the smallest grid with
        // extreme values, so every stage clips.
        reg_write(rk4s_pkg::REG_LAP, 32'd16777216);
        reg_write(rk4s_pkg::REG_NPTS, 32'd3);
        send(rk4s_pkg::OP_LOAD, 12'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send(rk4s_pkg::OP_LOAD, 12'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send(rk4s_pkg::OP_LOAD, 12'd2, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        for (int j = 0; j < 3; j++)
            send(rk4s_pkg::OP_READ, 12'(j), $urandom, $urandom, $urandom);
        send(rk4s_pkg::OP_STEP, 12'($urandom), $urandom, $urandom, $urandom);
        for (int j = 0; j < 3; j++)
            send(rk4s_pkg::OP_READ, 12'(j), '0, '0, '0);
        send(rk4s_pkg::OP_STEP, 12'hFFF, '0, '0, '0);
        send(rk4s_pkg::OP_LOAD, 12'hFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send(rk4s_pkg::OP_READ, 12'hFFF, '0, '0, '0);

        // zero lap coefficient: only the potential term acts
        settle();
        reg_write(rk4s_pkg::REG_LAP, 32'd0);
        reg_write(rk4s_pkg::REG_NPTS, 32'd5);
        load_grid(5);
        send(rk4s_pkg::OP_STEP, '0, '0, '0, '0);
        for (int j = 1; j < 4; j++)
            send(rk4s_pkg::OP_READ, 12'(j), '0, '0, '0);

        // Random phases: fresh settings, whole grid loaded, then a mix of
        // loads anywhere, reads of written points and steps.
        for (int ph = 0; ph < 3; ph++)
        begin
            settle();
            case ($urandom_range(0, 2))
                0: lap = 25'd0;
                1: lap = 25'd16777216;
                default: lap = 25'($urandom_range(0, 16777216));
            endcase
            n = $urandom_range(3, 12);
            reg_write(rk4s_pkg::REG_LAP, 32'(lap));
            reg_write(rk4s_pkg::REG_NPTS, 32'(n));
            load_grid(n);
            for (int k = 0; k < 12; k++)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 8)
                    send(rk4s_pkg::OP_LOAD, 12'($urandom),
                         wave_value(), wave_value(), wave_value());
                else if (pick < 15)
                begin
                    do
                        ix = 12'($urandom);
                    while (!written[ix] && $urandom_range(0, 3) != 0);
                    if (!written[ix])
                        ix = 12'($urandom_range(0, n - 1));
                    send(rk4s_pkg::OP_READ, ix, $urandom, $urandom, $urandom);
                end
                else
                    send(rk4s_pkg::OP_STEP, 12'($urandom), $urandom, $urandom, $urandom);
            end
        end

        // Calm tail: reset coefficient on a 16-point grid, one step.
        settle();
        calm = 1'b1;
        reg_write(rk4s_pkg::REG_LAP, 32'(rk4s_pkg::LAP_RESET));
        reg_write(rk4s_pkg::REG_NPTS, 32'd16);
        load_grid(16);
        send(rk4s_pkg::OP_STEP, '0, '0, '0, '0);
        send(rk4s_pkg::OP_READ, 12'd0, '0, '0, '0);
        send(rk4s_pkg::OP_READ, 12'd1, '0, '0, '0);
        send(rk4s_pkg::OP_READ, 12'd8, '0, '0, '0);
        send(rk4s_pkg::OP_READ, 12'd14, '0, '0, '0);
        send(rk4s_pkg::OP_READ, 12'd15, '0, '0, '0);
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Covered %0d loads, %0d reads and %0d RK4 steps", n_loads, n_reads, n_steps);
        $display("on grids from 3 to 16 points, lap coefficient from 0 to 1.0.");
        if (errors == 0 && pending == 0)
            $display("rk4_schrodinger_grid_step: match");
        else
            $display("rk4_schrodinger_grid_step: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
hdl/rk4s_pkg.sv
hdl/rk4s_ram.sv
hdl/rk4s_stage_unit.sv
hdl/rk4s_update_unit.sv
hdl/rk4_schrodinger_grid_step.sv
tb/rk4_grid_step_checker.sv
tb/rk4_schrodinger_grid_step_tb.sv
